// ===== design/ucs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types for the URL component splitter: item layouts of the input
// and result channels. No dependencies.
package ucs_pkg;

	localparam int CharW   = 8;
	localparam int PartW   = 3;
	localparam int FateW   = 2;

	typedef struct packed {
		logic [CharW-1:0] byte_in;
		logic             last_in;
	} url_item_t;

	typedef struct packed {
		logic [CharW-1:0] byte_out;
		logic [PartW-1:0] part;
		logic [FateW-1:0] pending_fate;
		logic             last_out;
		logic             status;
	} label_item_t;

endpackage

// ===== design/ucs_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one item of a given payload type.
// Used with the item types of ucs_pkg.
interface ucs_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/url_component_splitter.sv =====
`timescale 1ns / 1ps
// URL component splitter top level. Depends on ucs_pkg and ucs_stream_if.
//
// Labels each URL byte as scheme, host, port, path, query, tag, delimiter
// or pending space, one item per clock cycle unless labels stalls. Each
// input item yields exactly one result item in the next cycle from a
// result register; the phase update is one state transition, so a new
// byte is taken every cycle while the result register is empty or being
// drained. A byte with last_in set ends the URL, carries the final status
// (1: URL incomplete or no "://" after scheme; discard) and resets the parser.
module url_component_splitter (
	input  logic              clk,
	input  logic              arst_n,
	ucs_stream_if.sink        url,
	ucs_stream_if.source      labels
);
	import ucs_pkg::*;

	localparam logic [3:0] PH_START  = 4'd0;
	localparam logic [3:0] PH_SCHEME = 4'd1;
	localparam logic [3:0] PH_COLON  = 4'd2;
	localparam logic [3:0] PH_SLASH1 = 4'd3;
	localparam logic [3:0] PH_HOST   = 4'd4;
	localparam logic [3:0] PH_PORT   = 4'd5;
	localparam logic [3:0] PH_PATH   = 4'd6;
	localparam logic [3:0] PH_QUERY  = 4'd7;
	localparam logic [3:0] PH_TAG    = 4'd8;
	localparam logic [3:0] PH_DONE   = 4'd9;
	localparam logic [3:0] PH_FAIL   = 4'd10;

	localparam logic [PartW-1:0] PART_NONE   = 3'd0;
	localparam logic [PartW-1:0] PART_SCHEME = 3'd1;
	localparam logic [PartW-1:0] PART_HOST   = 3'd2;
	localparam logic [PartW-1:0] PART_PORT   = 3'd3;
	localparam logic [PartW-1:0] PART_PATH   = 3'd4;
	localparam logic [PartW-1:0] PART_QUERY  = 3'd5;
	localparam logic [PartW-1:0] PART_TAG    = 3'd6;
	localparam logic [PartW-1:0] PART_SPACE  = 3'd7;

	localparam logic [FateW-1:0] FATE_NONE    = 2'd0;
	localparam logic [FateW-1:0] FATE_JOINED  = 2'd1;
	localparam logic [FateW-1:0] FATE_DROPPED = 2'd2;

	localparam logic [CharW-1:0] CH_SPACE = 8'h20;
	localparam logic [CharW-1:0] CH_SLASH = 8'h2F;
	localparam logic [CharW-1:0] CH_COLON = 8'h3A;
	localparam logic [CharW-1:0] CH_QMARK = 8'h3F;
	localparam logic [CharW-1:0] CH_HASH  = 8'h23;
	localparam logic [CharW-1:0] CH_NUL   = 8'h00;

	logic [3:0]       phase_q;
	logic             pending_q;
	logic             out_valid_q;
	label_item_t      out_q;

	logic [CharW-1:0] c;
	logic [3:0]       phase_d;
	logic             pending_d;
	logic [PartW-1:0] part_d;
	logic [FateW-1:0] fate_d;
	logic             status_d;
	logic             accept;

	assign c      = url.payload.byte_in;
	assign url.ready = !out_valid_q || labels.ready;
	assign accept = url.valid && url.ready;

	always_comb begin
		phase_d   = phase_q;
		pending_d = pending_q;
		part_d    = PART_NONE;
		fate_d    = FATE_NONE;
		unique case (phase_q)
			PH_START: begin
				if (c == CH_SPACE) begin
					part_d    = PART_SPACE;
					pending_d = 1'b1;
				end else if (c == CH_SLASH) begin
					if (pending_q) fate_d = FATE_DROPPED;
					phase_d = PH_PATH;
				end else begin
					if (pending_q) fate_d = FATE_JOINED;
					if (c == CH_COLON) begin
						phase_d = PH_COLON;
					end else begin
						part_d  = PART_SCHEME;
						phase_d = PH_SCHEME;
					end
				end
			end
			PH_SCHEME: begin
				if (c == CH_COLON) phase_d = PH_COLON;
				else part_d = PART_SCHEME;
			end
			PH_COLON:  phase_d = (c == CH_SLASH) ? PH_SLASH1 : PH_FAIL;
			PH_SLASH1: phase_d = (c == CH_SLASH) ? PH_HOST : PH_FAIL;
			PH_HOST: begin
				if (c == CH_COLON) phase_d = PH_PORT;
				else if (c == CH_SLASH) phase_d = PH_PATH;
				else if (c == CH_QMARK) phase_d = PH_QUERY;
				else part_d = PART_HOST;
			end
			PH_PORT: begin
				if (c == CH_SLASH) phase_d = PH_PATH;
				else if (c == CH_QMARK) phase_d = PH_QUERY;
				else part_d = PART_PORT;
			end
			PH_PATH: begin
				if (c == CH_QMARK) phase_d = PH_QUERY;
				else if (c == CH_HASH) phase_d = PH_TAG;
				else part_d = PART_PATH;
			end
			PH_QUERY: begin
				if (c == CH_HASH) phase_d = PH_TAG;
				else part_d = PART_QUERY;
			end
			PH_TAG: begin
				if (c == CH_NUL) phase_d = PH_DONE;
				else part_d = PART_TAG;
			end
			PH_DONE: ;
			default: phase_d = PH_FAIL;
		endcase
	end

	// url incomplete or broken at its final byte
	assign status_d = url.payload.last_in &&
		(phase_d == PH_FAIL || phase_d == PH_START || phase_d == PH_SCHEME ||
		 phase_d == PH_COLON || phase_d == PH_SLASH1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (url.payload.last_in) begin
					phase_q   <= PH_START;
					pending_q <= 1'b0;
				end else begin
					phase_q   <= phase_d;
					pending_q <= pending_d;
				end
				out_valid_q <= 1'b1;
			end else if (labels.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.byte_out     <= c;
			out_q.part         <= part_d;
			out_q.pending_fate <= fate_d;
			out_q.last_out     <= url.payload.last_in;
			out_q.status       <= status_d;
		end
	end

	assign labels.valid   = out_valid_q;
	assign labels.payload = out_q;

endmodule
